// ===== hw/rtl/tpt_pkg.sv =====
// shared types and register codes for the tracker presence table
`default_nettype none
package tpt_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOST_TIMEOUT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HISTORY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_THRESH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TRACKERS    = 3'd4;

    localparam logic MODE_SIGHTING = 1'b0;
    localparam logic MODE_REFRESH  = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [31:0] now_ms;
        logic [7:0]  address_kind;
        logic [47:0] device_address;
        logic        has_payload;
    } tpt_in_t;

    typedef struct packed {
        logic       matched;
        logic [4:0] entry_index;
        logic       storage_full_event;
        logic       dropped;
        logic       history_trimmed;
        logic [5:0] lost_count;
    } tpt_out_t;

    typedef struct packed {
        logic [31:0] sample_gap_ms;
        logic [31:0] silence_limit_ms;
        logic [2:0]  history_limit;
        logic [5:0]  notify_threshold;
        logic [5:0]  tracker_limit;
    } tpt_cfg_t;

    typedef struct packed {
        logic [7:0]  kind;
        logic [47:0] addr;
    } tpt_key_t;

    // newest presence record of an entry
    typedef struct packed {
        logic        present;
        logic [31:0] hit_total;
        logic [31:0] first_ms;
        logic [31:0] last_sample_ms;
        logic [31:0] last_seen_ms;
        logic [31:0] lost_ms;
    } tpt_rec_t;

    // per-beat sweep control handed to the update unit
    typedef struct packed {
        logic found;
        logic at_free;
        logic drop;
    } tpt_ctl_t;

    // update unit status back to the sequencer
    typedef struct packed {
        logic hit;
        logic created;
        logic trimmed;
        logic lost;
    } tpt_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/tpt_cell.sv =====
// one table entry cell of the rotating entry chain
`default_nettype none
module tpt_cell
    import tpt_pkg::*;
#(
    parameter int unsigned HEAD_W = 3,
    parameter int unsigned FILL_W = 4
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift,
    input  wire logic              used_d,
    input  wire tpt_key_t          key_d,
    input  wire tpt_rec_t          rec_d,
    input  wire logic [HEAD_W-1:0] head_d,
    input  wire logic [FILL_W-1:0] fill_d,
    output logic                   used_q,
    output tpt_key_t               key_q,
    output tpt_rec_t               rec_q,
    output logic [HEAD_W-1:0]      head_q,
    output logic [FILL_W-1:0]      fill_q
);

    logic              used_reg;
    logic [HEAD_W-1:0] head_reg;
    logic [FILL_W-1:0] fill_reg;
    tpt_key_t          key_reg;
    tpt_rec_t          rec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            head_reg <= '0;
            fill_reg <= '0;
        end
        else if (shift)
        begin
            used_reg <= used_d;
            head_reg <= head_d;
            fill_reg <= fill_d;
        end
    end

    // key and record are only read behind used and fill
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            key_reg <= key_d;
            rec_reg <= rec_d;
        end
    end

    assign used_q = used_reg;
    assign key_q  = key_reg;
    assign rec_q  = rec_reg;
    assign head_q = head_reg;
    assign fill_q = fill_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/tpt_update.sv =====
// entry update unit at the end of the chain
`default_nettype none
module tpt_update
    import tpt_pkg::*;
#(
    parameter int unsigned HISTORY_DEPTH = 8,
    parameter int unsigned HEAD_W = 3,
    parameter int unsigned FILL_W = 4
) (
    input  wire tpt_in_t           item,
    input  wire tpt_cfg_t          cfg,
    input  wire tpt_ctl_t          ctl,
    input  wire logic              used_i,
    input  wire tpt_key_t          key_i,
    input  wire tpt_rec_t          rec_i,
    input  wire logic [HEAD_W-1:0] head_i,
    input  wire logic [FILL_W-1:0] fill_i,
    output logic                   used_o,
    output tpt_key_t               key_o,
    output tpt_rec_t               rec_o,
    output logic [HEAD_W-1:0]      head_o,
    output logic [FILL_W-1:0]      fill_o,
    output tpt_sts_t               sts
);

    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(HISTORY_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);

    tpt_rec_t          fresh;
    logic [HEAD_W-1:0] h;
    logic [FILL_W-1:0] f;
    logic              key_eq;

    always_comb
    begin
        fresh.present        = 1'b1;
        fresh.hit_total      = 32'd1;
        fresh.first_ms       = item.now_ms;
        fresh.last_sample_ms = item.now_ms;
        fresh.last_seen_ms   = item.now_ms;
        fresh.lost_ms        = 32'd0;

        key_eq = (key_i.kind == item.address_kind) && (key_i.addr == item.device_address);

        used_o = used_i;
        key_o  = key_i;
        rec_o  = rec_i;
        h      = head_i;
        f      = fill_i;
        sts    = '0;

        if (item.mode == MODE_REFRESH)
        begin
            if (cfg.silence_limit_ms != 32'd0 && used_i && fill_i != '0 && rec_i.present
                && item.now_ms >= 32'(rec_i.last_seen_ms + cfg.silence_limit_ms))
            begin
                rec_o.present = 1'b0;
                rec_o.lost_ms = item.now_ms;
                sts.lost      = 1'b1;
            end
        end
        else if (!ctl.found && used_i && key_eq)
        begin
            sts.hit = 1'b1;
            if (fill_i == '0 || !rec_i.present)
            begin
                // open a new record, pushing out the oldest if the ring is full
                if (f >= FILL_FULL)
                begin
                    h = (h == HEAD_LAST) ? '0 : h + 1'b1;
                    f = f - 1'b1;
                    sts.trimmed = 1'b1;
                end
                f     = f + 1'b1;
                rec_o = fresh;
            end
            else
            begin
                if (item.now_ms >= 32'(rec_i.last_sample_ms + cfg.sample_gap_ms))
                begin
                    rec_o.hit_total      = rec_i.hit_total + 32'd1;
                    rec_o.last_sample_ms = item.now_ms;
                end
                rec_o.last_seen_ms = item.now_ms;
            end
            if (8'(f) > 8'(cfg.history_limit))
            begin
                h = (h == HEAD_LAST) ? '0 : h + 1'b1;
                f = f - 1'b1;
                sts.trimmed = 1'b1;
            end
        end
        else if (!ctl.found && ctl.at_free && !ctl.drop)
        begin
            sts.created = 1'b1;
            used_o      = 1'b1;
            key_o.kind  = item.has_payload ? item.address_kind : 8'd0;
            key_o.addr  = item.has_payload ? item.device_address : 48'd0;
            h           = '0;
            f           = FILL_W'(1);
            rec_o       = fresh;
        end

        head_o = h;
        fill_o = f;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/tracker_presence_table.sv =====
// tracker presence table top level: entry chain, update unit and sequencer
`default_nettype none
// The table keeps up to MAX_TRACKERS tracker entries in a ring of cells that
// rotates by one entry per cycle during an unstalled sweep; the entry leaving
// the last cell passes through a single update unit and re-enters at the
// first cell. Each item (sighting or refresh) is taken when the block is
// idle and then walks the whole table once, and no new item is taken until
// that sweep has ended. The result beat sits in an output register; a new
// item may be taken while it waits, and the sweep only stalls on its last
// step if the previous result has still not been taken. Each entry keeps its
// key, ring head and fill count and the state of its newest presence record,
// which is all that later items can observe. Configuration writes go straight
// to the registers and are expected only while the block is idle.
module tracker_presence_table
    import tpt_pkg::*;
#(
    parameter int unsigned MAX_TRACKERS  = 32,
    parameter int unsigned HISTORY_DEPTH = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire tpt_in_t               in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output tpt_out_t                   out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned IDX_W  = (MAX_TRACKERS > 1) ? $clog2(MAX_TRACKERS) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_TRACKERS + 1);
    localparam int unsigned HEAD_W = $clog2(HISTORY_DEPTH);
    localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(MAX_TRACKERS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_TRACKERS);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_SWEEP = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    tpt_cfg_t          cfg_reg;
    tpt_in_t           item_reg;
    logic [IDX_W-1:0]  step_reg;
    logic [CNT_W-1:0]  count_reg;      // used entries
    logic [CNT_W-1:0]  base_reg;       // used entries when the item arrived
    logic [CNT_W-1:0]  lost_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic              found_reg;
    logic              created_reg;
    logic              trimmed_reg;
    logic              full_ev_reg;
    logic              drop_reg;
    logic              out_valid_reg;
    tpt_out_t          out_reg;
    tpt_out_t          out_next;

    // rotating entry chain
    logic              c_used [MAX_TRACKERS];
    tpt_key_t          c_key  [MAX_TRACKERS];
    tpt_rec_t          c_rec  [MAX_TRACKERS];
    logic [HEAD_W-1:0] c_head [MAX_TRACKERS];
    logic [FILL_W-1:0] c_fill [MAX_TRACKERS];

    logic              u_used;
    tpt_key_t          u_key;
    tpt_rec_t          u_rec;
    logic [HEAD_W-1:0] u_head;
    logic [FILL_W-1:0] u_fill;
    tpt_ctl_t          ctl;
    tpt_sts_t          sts;

    logic accept;
    logic last_step;
    logic out_free;
    logic shift;
    logic finish;
    logic full_now;

    assign accept    = in_valid && in_ready;
    assign last_step = (step_reg == STEP_LAST);
    assign out_free  = !out_valid_reg || out_ready;
    // hold the last step until the previous result beat is gone
    assign shift     = (state_reg == ST_SWEEP) && (!last_step || out_free);
    assign finish    = (state_reg == ST_SWEEP) && last_step && out_free;
    assign in_ready  = (state_reg == ST_IDLE);
    assign full_now  = (9'(count_reg) >= 9'(cfg_reg.notify_threshold));

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TRACKERS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                tpt_cell #(.HEAD_W(HEAD_W), .FILL_W(FILL_W)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .used_d(u_used), .key_d(u_key), .rec_d(u_rec),
                    .head_d(u_head), .fill_d(u_fill),
                    .used_q(c_used[gi]), .key_q(c_key[gi]), .rec_q(c_rec[gi]),
                    .head_q(c_head[gi]), .fill_q(c_fill[gi])
                );
            end
            else
            begin : g_next
                tpt_cell #(.HEAD_W(HEAD_W), .FILL_W(FILL_W)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .used_d(c_used[gi-1]), .key_d(c_key[gi-1]), .rec_d(c_rec[gi-1]),
                    .head_d(c_head[gi-1]), .fill_d(c_fill[gi-1]),
                    .used_q(c_used[gi]), .key_q(c_key[gi]), .rec_q(c_rec[gi]),
                    .head_q(c_head[gi]), .fill_q(c_fill[gi])
                );
            end
        end
    endgenerate

    // entry number step_reg is leaving the last cell on this step
    assign ctl.found   = found_reg;
    assign ctl.at_free = (CNT_W'(step_reg) == base_reg);
    assign ctl.drop    = drop_reg;

    tpt_update #(
        .HISTORY_DEPTH(HISTORY_DEPTH),
        .HEAD_W(HEAD_W),
        .FILL_W(FILL_W)
    ) u_update (
        .item(item_reg), .cfg(cfg_reg), .ctl(ctl),
        .used_i(c_used[MAX_TRACKERS-1]), .key_i(c_key[MAX_TRACKERS-1]),
        .rec_i(c_rec[MAX_TRACKERS-1]), .head_i(c_head[MAX_TRACKERS-1]),
        .fill_i(c_fill[MAX_TRACKERS-1]),
        .used_o(u_used), .key_o(u_key), .rec_o(u_rec),
        .head_o(u_head), .fill_o(u_fill), .sts(sts)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_SWEEP;
            ST_SWEEP: if (finish) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_gap_ms    <= 32'd1000;
            cfg_reg.silence_limit_ms <= 32'd60000;
            cfg_reg.history_limit    <= 3'd7;
            cfg_reg.notify_threshold <= 6'd24;
            cfg_reg.tracker_limit    <= 6'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SAMPLE_INTERVAL: cfg_reg.sample_gap_ms    <= cfg_data;
                REG_LOST_TIMEOUT:    cfg_reg.silence_limit_ms <= cfg_data;
                REG_MAX_HISTORY:     cfg_reg.history_limit    <= cfg_data[2:0];
                REG_NOTIFY_THRESH:   cfg_reg.notify_threshold <= cfg_data[5:0];
                REG_MAX_TRACKERS:    cfg_reg.tracker_limit    <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    // sequencer and sweep flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            count_reg     <= '0;
            base_reg      <= '0;
            lost_reg      <= '0;
            hit_idx_reg   <= '0;
            found_reg     <= 1'b0;
            created_reg   <= 1'b0;
            trimmed_reg   <= 1'b0;
            full_ev_reg   <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // a finishing sweep refills the output as the old beat leaves
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                step_reg    <= '0;
                base_reg    <= count_reg;
                lost_reg    <= '0;
                found_reg   <= 1'b0;
                created_reg <= 1'b0;
                trimmed_reg <= 1'b0;
                // threshold decisions only matter for a sighting that finds no entry
                full_ev_reg <= full_now;
                drop_reg    <= (full_now
                                && 9'(count_reg) >= 9'(cfg_reg.tracker_limit))
                               || (count_reg >= CNT_MAX);
            end
            if (shift)
            begin
                step_reg <= last_step ? '0 : step_reg + 1'b1;
                if (sts.hit)
                begin
                    found_reg   <= 1'b1;
                    hit_idx_reg <= step_reg;
                    trimmed_reg <= sts.trimmed;
                end
                if (sts.created)
                begin
                    created_reg <= 1'b1;
                    count_reg   <= count_reg + 1'b1;
                end
                if (sts.lost)
                begin
                    lost_reg <= lost_reg + 1'b1;
                end
            end
        end
    end

    // result beat, built from the flags including the final step
    always_comb
    begin
        out_next = '0;
        if (item_reg.mode == MODE_REFRESH)
        begin
            out_next.lost_count = 6'(lost_reg + CNT_W'(sts.lost));
        end
        else if (found_reg || sts.hit)
        begin
            out_next.matched         = 1'b1;
            out_next.entry_index     = found_reg ? 5'(hit_idx_reg) : 5'(step_reg);
            out_next.history_trimmed = found_reg ? trimmed_reg : sts.trimmed;
        end
        else
        begin
            out_next.storage_full_event = full_ev_reg;
            out_next.dropped            = drop_reg;
            out_next.entry_index        = (created_reg || sts.created)
                                          ? 5'(base_reg) : 5'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== tb/tracker_presence_table_tb.sv =====
// self-checking testbench for the tracker presence table
`timescale 1ns / 100ps
`default_nettype none
module tracker_presence_table_tb;
    import tpt_pkg::*;

    localparam int unsigned TRACKERS = 32;
    localparam int unsigned DEPTH    = 8;
    localparam int unsigned SETTLE   = 2 * (TRACKERS + 1) + 8;   // beyond one full sweep
    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned KEY_POOL = 40;                      // more keys than entries

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     in_valid = 1'b0;
    logic     in_ready;
    tpt_in_t  in_data = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    tpt_out_t out_data;
    logic     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SAMPLE_INTERVAL;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #6 clk = ~clk;

    tracker_presence_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // shadow copy of the table: configuration, keys, rings and records
    // ------------------------------------------------------------------
    tpt_cfg_t    cfg_shadow;
    logic        tbl_used [TRACKERS];
    tpt_key_t    tbl_key  [TRACKERS];
    logic [2:0]  tbl_head [TRACKERS];
    logic [3:0]  tbl_fill [TRACKERS];
    logic [5:0]  tbl_count;
    logic        rec_present [TRACKERS*DEPTH];
    logic [31:0] rec_found   [TRACKERS*DEPTH];
    logic [31:0] rec_sample  [TRACKERS*DEPTH];
    logic [31:0] rec_seen    [TRACKERS*DEPTH];

    // results still owed by the block, oldest first
    tpt_out_t owed_results [$];

    int unsigned mismatches = 0;
    int unsigned items_sent = 0;
    int unsigned results_seen = 0;
    int unsigned drops_seen = 0;
    int unsigned trims_seen = 0;
    int unsigned losses_seen = 0;
    int unsigned matches_seen = 0;

    // stimulus knobs, changed per phase
    int unsigned send_gap_pct = 0;
    int unsigned sink_stall_pct = 0;
    logic [31:0] clock_ms = 32'd0;
    tpt_key_t    key_pool [KEY_POOL];

    function automatic int unsigned newest_rec(int unsigned e);
        return e * DEPTH + ((tbl_head[e] + tbl_fill[e] - 1) % DEPTH);
    endfunction

    // one beat of the block: updates the shadow table and returns its result
    function automatic tpt_out_t predict_result(tpt_in_t it);
        tpt_out_t    r;
        int unsigned e;
        int unsigned s;
        bit          hit;
        bit          drop;
        r = '0;
        hit = 1'b0;
        drop = 1'b0;
        if (it.mode == MODE_REFRESH) begin
            if (cfg_shadow.silence_limit_ms != 0) begin
                for (e = 0; e < TRACKERS; e++) begin
                    if (tbl_used[e] && tbl_fill[e] != 0) begin
                        s = newest_rec(e);
                        if (rec_present[s] &&
                            it.now_ms >= 32'(rec_seen[s] + cfg_shadow.silence_limit_ms)) begin
                            rec_present[s] = 1'b0;
                            r.lost_count = 6'(r.lost_count + 1);
                        end
                    end
                end
            end
            return r;
        end
        for (e = 0; e < TRACKERS; e++) begin
            if (tbl_used[e] && tbl_key[e].kind == it.address_kind &&
                tbl_key[e].addr == it.device_address) begin
                hit = 1'b1;
                break;
            end
        end
        if (hit) begin
            r.matched = 1'b1;
            r.entry_index = e[4:0];
            if (tbl_fill[e] == 0 || !rec_present[newest_rec(e)]) begin
                // newest record absent or none: open a fresh one
                if (tbl_fill[e] >= DEPTH) begin
                    tbl_head[e] = 3'(tbl_head[e] + 1);
                    tbl_fill[e] = 4'(tbl_fill[e] - 1);
                    r.history_trimmed = 1'b1;
                end
                tbl_fill[e] = 4'(tbl_fill[e] + 1);
                s = newest_rec(e);
                rec_present[s] = 1'b1;
                rec_found[s] = 32'd1;
                rec_sample[s] = it.now_ms;
                rec_seen[s] = it.now_ms;
            end
            else begin
                s = newest_rec(e);
                if (it.now_ms >= 32'(rec_sample[s] + cfg_shadow.sample_gap_ms)) begin
                    rec_found[s] = rec_found[s] + 32'd1;
                    rec_sample[s] = it.now_ms;
                end
                rec_seen[s] = it.now_ms;
            end
            if (it.has_payload)
                tbl_key[e] = '{kind: it.address_kind, addr: it.device_address};
            if (tbl_fill[e] > cfg_shadow.history_limit) begin
                tbl_head[e] = 3'(tbl_head[e] + 1);
                tbl_fill[e] = 4'(tbl_fill[e] - 1);
                r.history_trimmed = 1'b1;
            end
        end
        else begin
            if (tbl_count >= cfg_shadow.notify_threshold) begin
                r.storage_full_event = 1'b1;
                if (tbl_count >= cfg_shadow.tracker_limit)
                    drop = 1'b1;
            end
            if (tbl_count >= TRACKERS)
                drop = 1'b1;
            if (drop)
                r.dropped = 1'b1;
            else begin
                e = tbl_count;
                tbl_used[e] = 1'b1;
                // key only taken from a beat that carries payload
                tbl_key[e] = it.has_payload ?
                    '{kind: it.address_kind, addr: it.device_address} : '0;
                tbl_head[e] = 3'd0;
                tbl_fill[e] = 4'd1;
                s = newest_rec(e);
                rec_present[s] = 1'b1;
                rec_found[s] = 32'd1;
                rec_sample[s] = it.now_ms;
                rec_seen[s] = it.now_ms;
                tbl_count = 6'(tbl_count + 1);
                r.entry_index = e[4:0];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("mismatch @%0t result %0d: %s got %0h, expected %0h",
                 $realtime, results_seen, field, got, want);
    endtask

    // ------------------------------------------------------------------
    // monitor: predicts on each accepted input beat and checks each
    // accepted result beat; also the no-progress watchdog
    // ------------------------------------------------------------------
    int unsigned quiet_cycles = 0;
    tpt_out_t    typed_result;
    bit          typed_valid = 1'b0;

    always @(posedge clk) begin
        tpt_out_t want;
        tpt_out_t pred;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                pred = predict_result(in_data);
                // a directed row with a typed answer overrides the predictor
                owed_results.insert(owed_results.size(), typed_valid ? typed_result : pred);
            end
            if (out_valid && out_ready) begin
                results_seen++;
                if (out_data.dropped) drops_seen++;
                if (out_data.history_trimmed) trims_seen++;
                if (out_data.matched) matches_seen++;
                losses_seen += out_data.lost_count;
                if (owed_results.size() == 0) begin
                    mismatches++;
                    $display("unexpected result beat @%0t", $realtime);
                end
                else begin
                    want = owed_results.pop_front();
                    if (out_data.matched !== want.matched)
                        report_mismatch("matched", out_data.matched, want.matched);
                    if (out_data.entry_index !== want.entry_index)
                        report_mismatch("entry_index", out_data.entry_index,
                                        want.entry_index);
                    if (out_data.storage_full_event !== want.storage_full_event)
                        report_mismatch("storage_full_event", out_data.storage_full_event,
                                        want.storage_full_event);
                    if (out_data.dropped !== want.dropped)
                        report_mismatch("dropped", out_data.dropped, want.dropped);
                    if (out_data.history_trimmed !== want.history_trimmed)
                        report_mismatch("history_trimmed", out_data.history_trimmed,
                                        want.history_trimmed);
                    if (out_data.lost_count !== want.lost_count)
                        report_mismatch("lost_count", out_data.lost_count,
                                        want.lost_count);
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // receiver back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= sink_stall_pct);

    // ------------------------------------------------------------------
    // driver tasks, entered and left at a falling edge
    // ------------------------------------------------------------------
    task automatic send_beat(tpt_in_t it);
        int unsigned gap;
        gap = 0;
        if (send_gap_pct != 0)
            while ($urandom_range(99) < send_gap_pct && gap < 12)
                gap++;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_SAMPLE_INTERVAL: cfg_shadow.sample_gap_ms = value;
            REG_LOST_TIMEOUT:    cfg_shadow.silence_limit_ms = value;
            REG_MAX_HISTORY:     cfg_shadow.history_limit = value[2:0];
            REG_NOTIFY_THRESH:   cfg_shadow.notify_threshold = value[5:0];
            REG_MAX_TRACKERS:    cfg_shadow.tracker_limit = value[5:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // drain: hold the sender until every owed result is back, then settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (owed_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic program_table(logic [31:0] interval, logic [31:0] timeout,
                                 logic [2:0] history, logic [5:0] notify,
                                 logic [5:0] limit);
        drain_results();
        write_reg(REG_SAMPLE_INTERVAL, interval);
        write_reg(REG_LOST_TIMEOUT, timeout);
        write_reg(REG_MAX_HISTORY, 32'(history));
        write_reg(REG_NOTIFY_THRESH, 32'(notify));
        write_reg(REG_MAX_TRACKERS, 32'(limit));
    endtask

    // random beat: mostly known keys so entries get hit again and again
    function automatic tpt_in_t random_beat();
        tpt_in_t     it;
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 2)
            clock_ms = $urandom;                         // arbitrary jump, wrap included
        else if (pick < 5)
            clock_ms = clock_ms + $urandom_range(200000);
        else
            clock_ms = clock_ms + $urandom_range(3000);
        it = '0;
        it.now_ms = clock_ms;
        it.mode = ($urandom_range(99) < 15) ? MODE_REFRESH : MODE_SIGHTING;
        if ($urandom_range(99) < 85) begin
            pick = $urandom_range(KEY_POOL - 1);
            it.address_kind = key_pool[pick].kind;
            it.device_address = key_pool[pick].addr;
            it.has_payload = ($urandom_range(99) < 85);
        end
        else begin
            it.address_kind = 8'($urandom);
            it.device_address = {16'($urandom), 32'($urandom)};
            it.has_payload = 1'($urandom);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // directed rows: typed answers only where they are obvious
    // ------------------------------------------------------------------
    typedef struct {
        tpt_in_t  beat;
        bit       typed;
        tpt_out_t answer;
    } directed_row_t;

    localparam logic [47:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] ADDR_ALT  = 48'h1234_5678_9ABC;

    function automatic directed_row_t row(logic mode, logic [31:0] now, logic [7:0] kind,
                                          logic [47:0] addr, logic pay, int unsigned typed,
                                          tpt_out_t answer);
        directed_row_t d;
        d.beat = '{mode: mode, now_ms: now, address_kind: kind,
                   device_address: addr, has_payload: pay};
        d.typed = (typed != 0);
        d.answer = answer;
        return d;
    endfunction

    function automatic tpt_out_t ans(int unsigned hit, int unsigned idx, int unsigned lost);
        tpt_out_t r;
        r = '0;
        r.matched = 1'(hit);
        r.entry_index = 5'(idx);
        r.lost_count = 6'(lost);
        return r;
    endfunction

    directed_row_t directed [$];

    // phase table for the random part
    typedef struct {
        logic [31:0] interval;
        logic [31:0] timeout;
        logic [2:0]  history;
        logic [5:0]  notify;
        logic [5:0]  limit;
        int unsigned beats;
    } phase_t;

    phase_t phases [$];

    initial begin
        int unsigned i;
        int unsigned p;
        // reset values of the registers
        cfg_shadow = '{sample_gap_ms: 32'd1000, silence_limit_ms: 32'd60000,
                       history_limit: 3'd7, notify_threshold: 6'd24,
                       tracker_limit: 6'd32};
        for (i = 0; i < TRACKERS; i++) begin
            tbl_used[i] = 1'b0;
            tbl_key[i] = '0;
            tbl_head[i] = '0;
            tbl_fill[i] = '0;
        end
        tbl_count = '0;
        key_pool[0] = '0;                                // matches payload-less entries
        key_pool[1] = '{kind: 8'hFF, addr: ADDR_ONES};
        for (i = 2; i < KEY_POOL; i++)
            key_pool[i] = '{kind: 8'($urandom_range(3)),
                            addr: {16'($urandom), 32'($urandom)}};

        // extremes of key fields, payload-less keys, loss and re-sighting
        directed.insert(directed.size(),
                        row(MODE_REFRESH,  32'd0, 8'h00, '0, 1'b0, 1, ans(0, 0, 0)));
        directed.insert(directed.size(),
                        row(MODE_SIGHTING, 32'd0, 8'hFF, ADDR_ONES, 1'b1, 1, ans(0, 0, 0)));
        directed.insert(directed.size(),
                        row(MODE_SIGHTING, 32'd500, 8'hFF, ADDR_ONES, 1'b1, 1, ans(1, 0, 0)));
        directed.insert(directed.size(),
                        row(MODE_SIGHTING, 32'd1500, 8'hFF, ADDR_ONES, 1'b0, 1, ans(1, 0, 0)));
        directed.insert(directed.size(),
                        row(MODE_SIGHTING, 32'd1600, 8'h00, '0, 1'b0, 1, ans(0, 1, 0)));
        directed.insert(directed.size(),
                        row(MODE_SIGHTING, 32'd1700, 8'h12, ADDR_ALT, 1'b0, 1, ans(0, 2, 0)));
        directed.insert(directed.size(),
                        row(MODE_SIGHTING, 32'd1800, 8'h00, '0, 1'b1, 1, ans(1, 1, 0)));
        directed.insert(directed.size(),
                        row(MODE_SIGHTING, 32'd1900, 8'h55, 48'h5555_5555_5555, 1'b1, 0, '0));
        directed.insert(directed.size(),
                        row(MODE_SIGHTING, 32'd2000, 8'hAA, 48'hAAAA_AAAA_AAAA, 1'b1, 0, '0));
        directed.insert(directed.size(),
                        row(MODE_REFRESH,  32'd2100, 8'hAA, ADDR_ONES, 1'b1, 1, ans(0, 0, 0)));
        directed.insert(directed.size(),
                        row(MODE_REFRESH,  32'd70000, 8'h00, '0, 1'b0, 1, ans(0, 0, 5)));
        directed.insert(directed.size(),
                        row(MODE_REFRESH,  32'd80000, 8'h00, '0, 1'b0, 1, ans(0, 0, 0)));
        for (i = 0; i < 9; i++) begin
            // lose and re-find entry zero, opening a new record in its ring each time
            directed.insert(directed.size(),
                            row(MODE_SIGHTING, 32'd100000 + i * 70000, 8'hFF, ADDR_ONES,
                                1'b1, 0, '0));
            if (i % 2 == 0)
                directed.insert(directed.size(),
                                row(MODE_REFRESH, 32'd165000 + i * 70000, 8'h00, '0,
                                    1'b0, 0, '0));
        end
        directed.insert(directed.size(),
                        row(MODE_REFRESH, 32'hFFFF_FFFF, 8'h00, '0, 1'b0, 0, '0));

        phases.insert(phases.size(), '{32'd1000, 32'd60000, 3'd7, 6'd2, 6'd7, 110});
        phases.insert(phases.size(), '{32'd0, 32'd1, 3'd1, 6'd0, 6'd0, 110});
        phases.insert(phases.size(), '{32'hFFFF_FFFF, 32'd0, 3'd0, 6'd32, 6'd32, 110});
        phases.insert(phases.size(), '{32'd500, 32'd5000, 3'd2, 6'd10, 6'd32, 110});
        phases.insert(phases.size(), '{32'd1000, 32'hFFFF_FFFF, 3'd7, 6'd24, 6'd32, 110});
        phases.insert(phases.size(), '{32'd100, 32'd3000, 3'd3, 6'd32, 6'd32, 110});

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at the reset settings, no idling
        foreach (directed[k]) begin
            typed_result = directed[k].answer;
            typed_valid = directed[k].typed;
            send_beat(directed[k].beat);
        end
        typed_valid = 1'b0;
        clock_ms = 32'd800000;

        // random part: each phase a new register setting and idle pattern
        for (p = 0; p < phases.size(); p++) begin
            program_table(phases[p].interval, phases[p].timeout, phases[p].history,
                          phases[p].notify, phases[p].limit);
            case (p % 4)
                0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_gap_pct = 76; sink_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  sink_stall_pct = 76; end
                default: begin send_gap_pct = 24; sink_stall_pct = 24; end
            endcase
            for (i = 0; i < phases[p].beats; i++)
                send_beat(random_beat());
        end
        drain_results();
        send_gap_pct = 0;
        sink_stall_pct = 0;

        $display("covered %0d beats, %0d results: %0d matched, %0d dropped, %0d trimmed",
                 items_sent, results_seen, matches_seen, drops_seen, trims_seen);
        $display("refresh sweeps marked %0d trackers lost over %0d register settings",
                 losses_seen, phases.size() + 1);
        if (mismatches == 0 && owed_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
`default_nettype wire
